/* rtl/pbu_pkg.sv */
// Shared types, constants, the unorm8 product and the saturating add of the pixel blend unit.
package pbu_pkg;

  localparam int COORD_BITS = 16;   // coordinate bits taken from the low end of pos_x/pos_y
  localparam int BOUND_W    = 15;   // surface size register width
  localparam int CHAN_W     = 8;    // one colour channel
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 32;

  // channel order inside every colour vector
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;
  localparam int CH_A = 3;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_INV_DST = 2'd1,
    MODE_ADD     = 2'd2,
    MODE_INV_SRC = 2'd3
  } blend_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_MODE     = 2'd0,
    REG_SURFACE_WIDTH  = 2'd1,
    REG_SURFACE_HEIGHT = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    blend_mode_t        mode;
    logic [BOUND_W-1:0] width;
    logic [BOUND_W-1:0] height;
  } pbu_cfg_t;

  typedef struct packed {
    logic signed [15:0]       pos_x;
    logic signed [15:0]       pos_y;
    logic [3:0][CHAN_W-1:0]   src;
    logic [3:0][CHAN_W-1:0]   dst;
  } pbu_pix_t;

  typedef struct packed {
    logic                     write_enable;
    logic [3:0][CHAN_W-1:0]   col;
  } pbu_res_t;

  // a*b/255 rounded to nearest: t = a*b + 128, result = (t + t/256) / 256
  function automatic logic [CHAN_W-1:0] unorm_mul(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [15:0] p;
    logic [16:0] t;
    logic [16:0] q;
    p = 16'(a) * 16'(b);
    t = 17'(p) + 17'd128;
    q = t + (t >> 8);
    return q[15:8];
  endfunction

  function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] s;
    s = (CHAN_W+1)'(a) + (CHAN_W+1)'(b);
    return s[CHAN_W] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
  endfunction

endpackage

/* rtl/pbu_blend.sv */
// Clip test and per-channel blend arithmetic for one pixel.
module pbu_blend (
  input  pbu_pkg::pbu_cfg_t cfg,
  input  pbu_pkg::pbu_pix_t pix,
  output pbu_pkg::pbu_res_t res
);

  logic [pbu_pkg::COORD_BITS-1:0] cx;
  logic [pbu_pkg::COORD_BITS-1:0] cy;
  logic                           on_surface;
  logic [3:0][pbu_pkg::CHAN_W-1:0] mul_a;
  logic [3:0][pbu_pkg::CHAN_W-1:0] mul_b;
  logic [3:0][pbu_pkg::CHAN_W-1:0] addend;
  logic [3:0][pbu_pkg::CHAN_W-1:0] prod;
  logic [3:0][pbu_pkg::CHAN_W-1:0] col;

  // take the coordinate from the low bits; negative or not below the bound clips
  assign cx = pix.pos_x[pbu_pkg::COORD_BITS-1:0];
  assign cy = pix.pos_y[pbu_pkg::COORD_BITS-1:0];
  assign on_surface = !cx[pbu_pkg::COORD_BITS-1] && !cy[pbu_pkg::COORD_BITS-1] &&
                      (33'(cx) < 33'(cfg.width)) && (33'(cy) < 33'(cfg.height));

  // one multiplier per lane, operands steered by the mode
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mul_a[i]  = pix.dst[i];
      mul_b[i]  = ~pix.src[pbu_pkg::CH_A];
      addend[i] = pix.src[i];
      if (cfg.mode != pbu_pkg::MODE_NORMAL) begin
        if (i == pbu_pkg::CH_A) begin
          mul_a[i]  = pix.src[pbu_pkg::CH_A];
          mul_b[i]  = ~pix.dst[pbu_pkg::CH_A];
          addend[i] = pix.dst[pbu_pkg::CH_A];
        end else if (cfg.mode == pbu_pkg::MODE_INV_DST) begin
          mul_a[i]  = pix.src[i];
          mul_b[i]  = ~pix.dst[i];
          addend[i] = '0;
        end else begin
          mul_a[i]  = pix.dst[i];
          mul_b[i]  = ~pix.src[i];
          addend[i] = '0;
        end
      end
      prod[i] = pbu_pkg::unorm_mul(mul_a[i], mul_b[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (cfg.mode == pbu_pkg::MODE_ADD && i != pbu_pkg::CH_A) begin
        col[i] = pbu_pkg::sat_add(pix.src[i], pix.dst[i]);
      end else begin
        col[i] = pbu_pkg::sat_add(prod[i], addend[i]);
      end
    end
  end

  always_comb begin
    res.write_enable = on_surface;
    res.col          = on_surface ? col : '0;
  end

endmodule

/* rtl/pixel_blend_unit_core.sv */
// Top level of the pixel blend unit: handshakes, configuration and pipeline registers.
//
// Premultiplied-alpha raster-op blend stage. Each input item carries a pixel position,
// a premultiplied source colour and the destination pixel already read from the surface;
// each one gives exactly one result item with a write enable and the blended RGBA colour.
// Pixels with a negative coordinate or one not below the configured surface size give
// write enable 0 and a zero colour. The block takes one item per clock when the output
// side keeps up: an item is first captured in the input register, the blend (one 8x8
// multiplier per channel with rounding and saturation) runs between that register and
// the output register, and out_tvalid rises once the result is in the output register.
// Both registers hold under back-pressure and in_tready falls only once both are full
// and out_tready is low.
// Configuration is a plain write port and must only be written while no item is in
// flight; register index 3 is ignored.
module pixel_blend_unit_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [pbu_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [pbu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x[15:0], pos_y[31:16], src_r, src_g, src_b, src_a, dst_r, dst_g, dst_b, dst_a
  input  logic [pbu_pkg::IN_DATA_W-1:0]     in_tdata,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_r[7:0], out_g[15:8], out_b[23:16], out_a[31:24]
  output logic [pbu_pkg::OUT_DATA_W-1:0]    out_tdata,
  // write_enable[0]
  output logic                              out_tuser
);

  pbu_pkg::pbu_cfg_t cfg_r, cfg_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  pbu_pkg::pbu_pix_t s1_pix_r, s1_pix_nxt;
  logic              s2_valid_r, s2_valid_nxt;
  pbu_pkg::pbu_res_t s2_res_r, s2_res_nxt;

  pbu_pkg::pbu_pix_t in_pix;
  pbu_pkg::pbu_res_t blend_res;
  logic              s1_ready;
  logic              s2_ready;

  // --- configuration: decode the index, drop writes beyond the list ---
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (pbu_pkg::cfg_reg_t'(cfg_addr))
        pbu_pkg::REG_BLEND_MODE:
          cfg_nxt.mode = pbu_pkg::blend_mode_t'(cfg_wdata[1:0]);
        pbu_pkg::REG_SURFACE_WIDTH:
          cfg_nxt.width = cfg_wdata[pbu_pkg::BOUND_W-1:0];
        pbu_pkg::REG_SURFACE_HEIGHT:
          cfg_nxt.height = cfg_wdata[pbu_pkg::BOUND_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // --- unpack the input item ---
  always_comb begin
    in_pix.pos_x = in_tdata[15:0];
    in_pix.pos_y = in_tdata[31:16];
    for (int i = 0; i < 4; i++) begin
      in_pix.src[i] = in_tdata[32 + 8*i +: 8];
      in_pix.dst[i] = in_tdata[64 + 8*i +: 8];
    end
  end

  // --- pipeline control: each stage advances when the one after it has room ---
  assign s2_ready  = !s2_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_pix_nxt   = s1_pix_r;
    if (s1_ready) begin
      s1_valid_nxt = in_tvalid;
      s1_pix_nxt   = in_pix;
    end
  end

  pbu_blend u_blend (
    .cfg (cfg_r),
    .pix (s1_pix_r),
    .res (blend_res)
  );

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    s2_res_nxt   = s2_res_r;
    if (s2_ready) begin
      s2_valid_nxt = s1_valid_r;
      s2_res_nxt   = blend_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= pbu_pkg::MODE_NORMAL;
      cfg_r.width  <= '0;
      cfg_r.height <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    s1_pix_r <= s1_pix_nxt;
    s2_res_r <= s2_res_nxt;
  end

  // --- pack the result item ---
  assign out_tvalid = s2_valid_r;
  assign out_tuser  = s2_res_r.write_enable;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      out_tdata[8*i +: 8] = s2_res_r.col[i];
    end
  end

  // --- checks ---
  // clipped pixels carry a zero colour
  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("clipped result with non-zero colour");

  // nothing leaves the block straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a held item moves to the output when the output stage has room
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_tvalid)
    else $error("item lost between stages");

  // an empty input register always takes a new item
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty stage");

endmodule
